// ===== hdl/utfd_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 decoder.
`default_nettype none
package utfd_pkg;

  // Escape code for a refused byte is ESC_BASE plus the byte value
  localparam logic [20:0] ESC_BASE  = 21'h00EE00;
  localparam logic [7:0]  LEAD_MIN  = 8'hC2;
  localparam logic [7:0]  LEAD_3    = 8'hE0;
  localparam logic [7:0]  LEAD_4    = 8'hF0;
  localparam logic [7:0]  LEAD_END  = 8'hF8;
  localparam logic [7:0]  ASCII_END = 8'h80;
  localparam logic [7:0]  ESC_HIGH  = 8'hEE;
  localparam logic [20:0] MIN_2     = 21'h000080;
  localparam logic [20:0] MIN_3     = 21'h000800;
  localparam logic [20:0] MIN_4     = 21'h010000;
  localparam logic [20:0] CP_LIMIT  = 21'h110000;

  // Sequence lengths
  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam int unsigned MAX_RES = 4;

  // One result: code point and decode-ok flag
  typedef struct packed {
    logic [20:0] code_point;
    logic        ok;
  } res_t;

  // All results caused by one input byte, entry 0 first
  typedef struct packed {
    logic [2:0]          count;
    res_t [MAX_RES-1:0]  ent;
  } batch_t;

  // Build the error escape for one byte
  function automatic res_t escape(input logic [7:0] b);
    res_t r;
    r.code_point = ESC_BASE + {13'd0, b};
    r.ok         = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/utfd_core.sv =====
// Sequence state and single-pass decode of one byte into a batch of results.
`default_nettype none
module utfd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             acc,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_text,
  output utfd_pkg::batch_t      batch
);

  logic [7:0] held [3];
  logic [7:0] held_next [3];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [2:0] exp_len;
  logic [2:0] exp_next;

  logic            is_cont;
  logic            is_lead;
  logic            f_en;
  utfd_pkg::res_t  f_res;
  logic            f_start;
  logic [2:0]      f_len;
  logic [20:0]     dec_cp;
  logic            dec_ok;
  logic [2:0]      total;
  logic [1:0]      flush_n;
  logic            tail_en;
  utfd_pkg::res_t  tail;

  assign is_cont = (in_byte[7:6] == 2'b10);
  assign is_lead = (in_byte >= utfd_pkg::LEAD_MIN) && (in_byte < utfd_pkg::LEAD_END);
  assign total   = {1'b0, cnt} + 3'd1;

  // Handle a byte that arrives with no sequence open
  always_comb begin
    f_en    = 1'b0;
    f_res   = utfd_pkg::escape(in_byte);
    f_start = 1'b0;
    f_len   = utfd_pkg::LEN_2;
    if (in_byte < utfd_pkg::ASCII_END) begin
      f_en  = 1'b1;
      f_res = '{code_point: {13'd0, in_byte}, ok: 1'b1};
    end else if (is_lead) begin
      if (end_of_text) begin
        f_en = 1'b1;
      end else begin
        f_start = 1'b1;
        if (in_byte < utfd_pkg::LEAD_3) begin
          f_len = utfd_pkg::LEN_2;
        end else if (in_byte < utfd_pkg::LEAD_4) begin
          f_len = utfd_pkg::LEN_3;
        end else begin
          f_len = utfd_pkg::LEN_4;
        end
      end
    end else begin
      f_en = 1'b1;
    end
  end

  // Decode the sequence completed by the current byte
  always_comb begin
    dec_cp = '0;
    dec_ok = 1'b0;
    case (exp_len)
      utfd_pkg::LEN_2: begin
        dec_cp = {10'd0, held[0][4:0], in_byte[5:0]};
        dec_ok = (dec_cp >= utfd_pkg::MIN_2);
      end
      utfd_pkg::LEN_3: begin
        dec_cp = {5'd0, held[0][3:0], held[1][5:0], in_byte[5:0]};
        dec_ok = (dec_cp >= utfd_pkg::MIN_3) && (dec_cp[15:8] != utfd_pkg::ESC_HIGH);
      end
      utfd_pkg::LEN_4: begin
        dec_cp = {held[0][2:0], held[1][5:0], held[2][5:0], in_byte[5:0]};
        dec_ok = (dec_cp >= utfd_pkg::MIN_4) && (dec_cp < utfd_pkg::CP_LIMIT);
      end
      default: begin
        dec_cp = '0;
        dec_ok = 1'b0;
      end
    endcase
  end

  // Choose flushed entries, trailing result and next sequence state
  always_comb begin
    held_next = held;
    cnt_next  = cnt;
    exp_next  = exp_len;
    flush_n   = 2'd0;
    tail_en   = 1'b0;
    tail      = utfd_pkg::escape(in_byte);
    if (cnt == 2'd0) begin
      tail_en = f_en;
      tail    = f_res;
      if (f_start) begin
        held_next[0] = in_byte;
        cnt_next     = 2'd1;
        exp_next     = f_len;
      end
    end else if (is_cont) begin
      if (total == exp_len) begin
        tail_en  = 1'b1;
        cnt_next = 2'd0;
        exp_next = utfd_pkg::LEN_IDLE;
        if (dec_ok) begin
          tail = '{code_point: dec_cp, ok: 1'b1};
        end else begin
          flush_n = cnt;
        end
      end else if ((cnt != 2'd3) && (total < exp_len)) begin
        held_next[cnt] = in_byte;
        cnt_next       = cnt + 2'd1;
        if (end_of_text) begin
          flush_n  = cnt;
          tail_en  = 1'b1;
          cnt_next = 2'd0;
          exp_next = utfd_pkg::LEN_IDLE;
        end
      end else begin
        flush_n  = cnt;
        tail_en  = 1'b1;
        cnt_next = 2'd0;
        exp_next = utfd_pkg::LEN_IDLE;
      end
    end else begin
      // broken sequence: flush, then treat the byte as fresh
      flush_n  = cnt;
      tail_en  = f_en;
      tail     = f_res;
      cnt_next = 2'd0;
      exp_next = utfd_pkg::LEN_IDLE;
      if (f_start) begin
        held_next[0] = in_byte;
        cnt_next     = 2'd1;
        exp_next     = f_len;
      end
    end
  end

  // Lay out the batch: held escapes first, then the trailing result
  always_comb begin
    batch.count = {1'b0, flush_n} + {2'd0, tail_en};
    for (int i = 0; i < utfd_pkg::MAX_RES; i++) begin
      if ((i < 3) && (i < int'(flush_n))) begin
        batch.ent[i] = utfd_pkg::escape(held[i % 3]);
      end else begin
        batch.ent[i] = tail;
      end
    end
  end

  // Advance sequence state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= 2'd0;
      exp_len <= utfd_pkg::LEN_IDLE;
    end else if (acc) begin
      cnt     <= cnt_next;
      exp_len <= exp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held <= held_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_match: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) == (exp_len == utfd_pkg::LEN_IDLE))
    else $error("held count and sequence length disagree on idle");
  a_cnt_below_len: assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd0) |-> ({1'b0, cnt} < exp_len))
    else $error("held count reached sequence length");
  a_eot_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && end_of_text) |=> (cnt == 2'd0))
    else $error("sequence open after end of text");
`endif

endmodule
`default_nettype wire

// ===== hdl/utfd_out.sv =====
// Result buffer that holds one batch and sends its entries one per cycle while m_tready is high.
`default_nettype none
module utfd_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire utfd_pkg::batch_t batch,
  input  wire logic             m_tready,
  output logic                  m_tvalid,
  output logic [23:0]           m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser,
  output logic                  room
);

  utfd_pkg::res_t ent [utfd_pkg::MAX_RES];
  logic [2:0]     rem;
  logic [1:0]     idx;

  assign m_tvalid = (rem != 3'd0);
  assign m_tdata  = {3'd0, ent[idx].code_point};
  assign m_tuser  = ent[idx].ok;
  assign m_tlast  = (rem == 3'd1);
  // free when empty or once the last pending result leaves this cycle
  assign room     = (rem == 3'd0) || ((rem == 3'd1) && m_tready);

  // Load a new batch or advance past the sent entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      rem <= batch.count;
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      rem <= rem - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < utfd_pkg::MAX_RES; i++) begin
        ent[i] <= batch.ent[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_span: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rem} + {2'd0, idx}) <= 4'd4)
    else $error("result pointer runs past the batch");
`endif

endmodule
`default_nettype wire

// ===== hdl/utf8_decoder_with_error_escape.sv =====
// Top level of the UTF-8 decoder with error escape.
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready is
// high; a byte that gives more than one result holds the input until its last result leaves the result buffer.
// Reset (rst, synchronous): drops any open sequence and any pending results.
`default_nettype none
module utf8_decoder_with_error_escape (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte[7:0]
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // code_point[20:0], zero [23:21]
  output logic             m_tlast,   // last_of_run
  output logic             m_tuser    // valid_res
);

  utfd_pkg::batch_t batch;
  logic             acc;
  logic             room;

  assign s_tready = room;
  assign acc      = s_tvalid && s_tready;

  // Decode each accepted request
  utfd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .in_byte     (s_tdata),
    .end_of_text (s_tlast),
    .batch       (batch)
  );

  // Hold and send the results
  utfd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (acc && (batch.count != 3'd0)),
    .batch    (batch),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .room     (room)
  );

endmodule
`default_nettype wire
